// ===== hdl/cprgba_pkg.sv =====
// Shared types and constants of the camera pixel format to RGBA converter.
// No dependencies; used by cprgba_yuv2rgb and camera_pixel_format_to_rgba_core.
`default_nettype none

package cprgba_pkg;

  localparam int unsigned FMT_W    = 3;
  localparam int unsigned FRAME_W  = 23;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam int unsigned MAX_PIXELS_DEF = 4194304;

  localparam logic [FMT_W-1:0]   PIXEL_FORMAT_RST = 3'd0;
  localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = 23'd307200;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;

  // Register index, taken from byte address bit 2.
  localparam logic REG_PIXEL_FORMAT = 1'b0;
  localparam logic REG_FRAME_PIXELS = 1'b1;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGBA  = 3'd0,
    FMT_BGRA  = 3'd1,
    FMT_RGB   = 3'd2,
    FMT_BGR   = 3'd3,
    FMT_YUYV  = 3'd4,
    FMT_UYVY  = 3'd5,
    FMT_BLACK = 3'd6
  } fmt_e;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
  } pixel_t;

endpackage

`default_nettype wire

// ===== hdl/cprgba_yuv2rgb.sv =====
// Integer BT.601 conversion of one Y/U/V triple into an opaque RGBA pixel.
// Depends on cprgba_pkg for the pixel type and byte constants.
`default_nettype none

module cprgba_yuv2rgb (
  input  wire logic [cprgba_pkg::BYTE_W-1:0] y_i,
  input  wire logic [cprgba_pkg::BYTE_W-1:0] u_i,
  input  wire logic [cprgba_pkg::BYTE_W-1:0] v_i,
  output cprgba_pkg::pixel_t                 pix_o
);

  localparam int unsigned SUM_W = 20;

  localparam logic signed [SUM_W-1:0] KY     = 20'sd298;
  localparam logic signed [SUM_W-1:0] KRV    = 20'sd409;
  localparam logic signed [SUM_W-1:0] KGU    = 20'sd100;
  localparam logic signed [SUM_W-1:0] KGV    = 20'sd208;
  localparam logic signed [SUM_W-1:0] KBU    = 20'sd516;
  localparam logic signed [SUM_W-1:0] RND    = 20'sd128;
  localparam logic signed [SUM_W-1:0] Y_OFS  = 20'sd16;
  localparam logic signed [SUM_W-1:0] UV_OFS = 20'sd128;
  localparam logic signed [SUM_W-1:0] BYTE_MAX = 20'sd255;

  logic signed [SUM_W-1:0] c_s;
  logic signed [SUM_W-1:0] d_s;
  logic signed [SUM_W-1:0] e_s;
  logic signed [SUM_W-1:0] r_sum;
  logic signed [SUM_W-1:0] g_sum;
  logic signed [SUM_W-1:0] b_sum;

  // Floor divide by 256 and saturate to a byte.
  function automatic logic [cprgba_pkg::BYTE_W-1:0] clamp_byte(
    input logic signed [SUM_W-1:0] sum
  );
    logic signed [SUM_W-1:0] q;
    q = sum >>> 8;
    if (q < 0) begin
      return cprgba_pkg::BYTE_ZERO;
    end else if (q > BYTE_MAX) begin
      return cprgba_pkg::ALPHA_OPAQUE;
    end else begin
      return q[cprgba_pkg::BYTE_W-1:0];
    end
  endfunction

  always_comb begin
    c_s   = $signed({12'b0, y_i}) - Y_OFS;
    d_s   = $signed({12'b0, u_i}) - UV_OFS;
    e_s   = $signed({12'b0, v_i}) - UV_OFS;
    r_sum = KY * c_s + KRV * e_s + RND;
    g_sum = KY * c_s - KGU * d_s - KGV * e_s + RND;
    b_sum = KY * c_s + KBU * d_s + RND;
    pix_o.red   = clamp_byte(r_sum);
    pix_o.green = clamp_byte(g_sum);
    pix_o.blue  = clamp_byte(b_sum);
    pix_o.alpha = cprgba_pkg::ALPHA_OPAQUE;
  end

endmodule

`default_nettype wire

// ===== hdl/camera_pixel_format_to_rgba_core.sv =====
// Top level of the camera pixel format to RGBA converter.
// Depends on cprgba_pkg and instantiates cprgba_yuv2rgb twice.
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       sink       in_valid_i / in_stall_o    source_byte_i
// out      source     out_valid_o / out_stall_i  red/green/blue/alpha, frame_end, run_last
// cfg      APB slave  psel/penable/pwrite/pready pixel_format (0x0), frame_pixels (0x4)
//
// A byte can be taken in every cycle while in_stall_o is low. A byte that completes a
// group is loaded into the item register at its transfer, and its pixels pass the YUV
// arithmetic into the result register once that register has room, so the first pixel
// reaches the output ports through the item register and then the result register.
// A YUV group gives two pixels, which leave one after the other from the result register; the byte
// stream never outruns the output, so throughput stays at one byte per cycle
// while the output side takes a pixel in every cycle. Reset clears the group
// phase, the held bytes, the pixel counter and both pipeline stages. A stall on
// the output side reaches the input stall in the same cycle only when both the
// item register and the result register are occupied.

module camera_pixel_format_to_rgba_core #(
  parameter int unsigned MAX_PIXELS = cprgba_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Byte input.
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [cprgba_pkg::BYTE_W-1:0]     source_byte_i,
  // Pixel output.
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [cprgba_pkg::BYTE_W-1:0]          red_o,
  output logic [cprgba_pkg::BYTE_W-1:0]          green_o,
  output logic [cprgba_pkg::BYTE_W-1:0]          blue_o,
  output logic [cprgba_pkg::BYTE_W-1:0]          alpha_o,
  output logic                                   frame_end_o,
  output logic                                   run_last_o,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [cprgba_pkg::APB_AW-1:0]     paddr,
  input  wire logic [cprgba_pkg::APB_DW-1:0]     pwdata,
  output logic [cprgba_pkg::APB_DW-1:0]          prdata,
  output logic                                   pready
);

  localparam int unsigned IDX_W = $clog2(MAX_PIXELS);
  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CMP_W =
    ((CNT_W > cprgba_pkg::FRAME_W) ? CNT_W : cprgba_pkg::FRAME_W) + 1;
  localparam int unsigned BW = cprgba_pkg::BYTE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the access phase; reads are
  // combinational from the address.
  // ---------------------------------------------------------------------------
  logic [cprgba_pkg::FMT_W-1:0]   pixel_format_q;
  logic [cprgba_pkg::FRAME_W-1:0] frame_pixels_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= cprgba_pkg::PIXEL_FORMAT_RST;
      frame_pixels_q <= cprgba_pkg::FRAME_PIXELS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == cprgba_pkg::REG_PIXEL_FORMAT) begin
        pixel_format_q <= pwdata[cprgba_pkg::FMT_W-1:0];
      end else begin
        frame_pixels_q <= pwdata[cprgba_pkg::FRAME_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == cprgba_pkg::REG_FRAME_PIXELS) begin
      prdata = cprgba_pkg::APB_DW'(frame_pixels_q);
    end else begin
      prdata = cprgba_pkg::APB_DW'(pixel_format_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: group assembly and pixel counting. All of the bookkeeping that
  // the next byte depends on is settled at the byte's transfer.
  // ---------------------------------------------------------------------------
  logic [1:0]       phase_q, phase_d;
  logic [BW-1:0]    held0_q, held0_d;
  logic [BW-1:0]    held1_q, held1_d;
  logic [BW-1:0]    held2_q, held2_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // Item register: one completed group (or one black pixel) waiting for the
  // YUV arithmetic and the result register.
  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_yuv_q, s1_yuv_d;
  logic                    s1_two_q, s1_two_d;
  logic                    s1_end0_q, s1_end0_d;
  logic                    s1_end1_q, s1_end1_d;
  cprgba_pkg::pixel_t      s1_pix_q, s1_pix_d;
  logic [BW-1:0]           s1_y0_q, s1_y0_d;
  logic [BW-1:0]           s1_y1_q, s1_y1_d;
  logic [BW-1:0]           s1_u_q, s1_u_d;
  logic [BW-1:0]           s1_v_q, s1_v_d;

  logic             in_acc;
  logic             s1_load_out;
  logic             three_byte;
  logic             complete;
  logic [BW-1:0]    b2;
  logic [CMP_W-1:0] frame_ext;
  logic [CMP_W-1:0] count_eff;
  logic [CMP_W-1:0] idx_p1;
  logic [CMP_W-1:0] idx_p2;
  logic             end0;
  logic             end1;

  cprgba_pkg::fmt_e fmt;

  assign fmt    = cprgba_pkg::fmt_e'(pixel_format_q);
  assign in_acc = in_valid_i && !in_stall_o;

  // Active pixel count: zero counts as one, and it saturates at MAX_PIXELS.
  always_comb begin
    frame_ext = CMP_W'(frame_pixels_q);
    if (frame_ext == '0) begin
      count_eff = CMP_W'(1);
    end else if (frame_ext > CMP_W'(MAX_PIXELS)) begin
      count_eff = CMP_W'(MAX_PIXELS);
    end else begin
      count_eff = frame_ext;
    end
    idx_p1 = CMP_W'(idx_q) + CMP_W'(1);
    idx_p2 = CMP_W'(idx_q) + CMP_W'(2);
    end0   = (idx_p1 >= count_eff);
    end1   = (idx_p2 >= count_eff);
  end

  always_comb begin
    three_byte = (fmt == cprgba_pkg::FMT_RGB) || (fmt == cprgba_pkg::FMT_BGR);
    // A byte at or past the last place of the current group completes it.
    complete   = three_byte ? (phase_q >= 2'd2) : (phase_q == 2'd3);
    b2         = three_byte ? source_byte_i : held2_q;

    phase_d    = phase_q;
    held0_d    = held0_q;
    held1_d    = held1_q;
    held2_d    = held2_q;
    idx_d      = idx_q;

    s1_valid_d = s1_valid_q && !s1_load_out;
    s1_yuv_d   = s1_yuv_q;
    s1_two_d   = s1_two_q;
    s1_end0_d  = s1_end0_q;
    s1_end1_d  = s1_end1_q;
    s1_pix_d   = s1_pix_q;
    s1_y0_d    = s1_y0_q;
    s1_y1_d    = s1_y1_q;
    s1_u_d     = s1_u_q;
    s1_v_d     = s1_v_q;

    if (in_acc) begin
      s1_end0_d = end0;
      s1_end1_d = end1;
      s1_two_d  = 1'b0;
      s1_yuv_d  = 1'b0;
      case (fmt)
        cprgba_pkg::FMT_RGBA, cprgba_pkg::FMT_BGRA, cprgba_pkg::FMT_RGB,
        cprgba_pkg::FMT_BGR, cprgba_pkg::FMT_YUYV, cprgba_pkg::FMT_UYVY: begin
          if (!complete) begin
            // Still gathering the group: park the byte.
            case (phase_q)
              2'd0: held0_d = source_byte_i;
              2'd1: held1_d = source_byte_i;
              default: held2_d = source_byte_i;
            endcase
            phase_d = phase_q + 2'd1;
          end else begin
            phase_d    = 2'd0;
            s1_valid_d = 1'b1;
            case (fmt)
              cprgba_pkg::FMT_RGBA: s1_pix_d = '{held0_q, held1_q, b2, source_byte_i};
              cprgba_pkg::FMT_BGRA: s1_pix_d = '{b2, held1_q, held0_q, source_byte_i};
              cprgba_pkg::FMT_RGB: begin
                s1_pix_d = '{held0_q, held1_q, b2, cprgba_pkg::ALPHA_OPAQUE};
              end
              cprgba_pkg::FMT_BGR: begin
                s1_pix_d = '{b2, held1_q, held0_q, cprgba_pkg::ALPHA_OPAQUE};
              end
              cprgba_pkg::FMT_YUYV: begin
                s1_yuv_d = 1'b1;
                s1_y0_d  = held0_q;
                s1_u_d   = held1_q;
                s1_y1_d  = held2_q;
                s1_v_d   = source_byte_i;
              end
              default: begin
                s1_yuv_d = 1'b1;
                s1_u_d   = held0_q;
                s1_y0_d  = held1_q;
                s1_v_d   = held2_q;
                s1_y1_d  = source_byte_i;
              end
            endcase
            if (s1_yuv_d) begin
              // The second pixel of a pair is dropped when the first ends the frame.
              s1_two_d = !end0;
              if (end0 || end1) begin
                idx_d = '0;
              end else begin
                idx_d = IDX_W'(idx_p2);
              end
            end else begin
              idx_d = end0 ? '0 : IDX_W'(idx_p1);
            end
          end
        end
        default: begin
          // Black and reserved codes: one opaque black pixel per byte; held bytes stay.
          s1_valid_d = 1'b1;
          s1_pix_d   = '{cprgba_pkg::BYTE_ZERO, cprgba_pkg::BYTE_ZERO,
                         cprgba_pkg::BYTE_ZERO, cprgba_pkg::ALPHA_OPAQUE};
          phase_d    = 2'd0;
          idx_d      = end0 ? '0 : IDX_W'(idx_p1);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 2'd0;
      held0_q    <= '0;
      held1_q    <= '0;
      held2_q    <= '0;
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      held0_q    <= held0_d;
      held1_q    <= held1_d;
      held2_q    <= held2_d;
      idx_q      <= idx_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_yuv_q  <= s1_yuv_d;
    s1_two_q  <= s1_two_d;
    s1_end0_q <= s1_end0_d;
    s1_end1_q <= s1_end1_d;
    s1_pix_q  <= s1_pix_d;
    s1_y0_q   <= s1_y0_d;
    s1_y1_q   <= s1_y1_d;
    s1_u_q    <= s1_u_d;
    s1_v_q    <= s1_v_d;
  end

  // ---------------------------------------------------------------------------
  // YUV arithmetic between the item register and the result register.
  // ---------------------------------------------------------------------------
  cprgba_pkg::pixel_t yuv0_pix;
  cprgba_pkg::pixel_t yuv1_pix;
  cprgba_pkg::pixel_t first_pix;

  cprgba_yuv2rgb u_yuv0 (
    .y_i   (s1_y0_q),
    .u_i   (s1_u_q),
    .v_i   (s1_v_q),
    .pix_o (yuv0_pix)
  );

  cprgba_yuv2rgb u_yuv1 (
    .y_i   (s1_y1_q),
    .u_i   (s1_u_q),
    .v_i   (s1_v_q),
    .pix_o (yuv1_pix)
  );

  assign first_pix = s1_yuv_q ? yuv0_pix : s1_pix_q;

  // ---------------------------------------------------------------------------
  // Result register: up to two pixels of one item. Slot 0 drives the ports and
  // slot 1 moves into it after slot 0's transfer. The item register unloads
  // once the result register is empty or about to become empty.
  // ---------------------------------------------------------------------------
  logic [1:0]         cnt_q, cnt_d;
  cprgba_pkg::pixel_t o0_pix_q, o0_pix_d;
  logic               o0_end_q, o0_end_d;
  logic               o0_last_q, o0_last_d;
  cprgba_pkg::pixel_t o1_pix_q, o1_pix_d;
  logic               o1_end_q, o1_end_d;
  logic               out_acc;

  assign out_acc     = (cnt_q != 2'd0) && !out_stall_i;
  assign s1_load_out = s1_valid_q &&
                       ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_acc));
  assign in_stall_o  = s1_valid_q && !s1_load_out;

  always_comb begin
    cnt_d     = cnt_q;
    o0_pix_d  = o0_pix_q;
    o0_end_d  = o0_end_q;
    o0_last_d = o0_last_q;
    o1_pix_d  = o1_pix_q;
    o1_end_d  = o1_end_q;
    if (s1_load_out) begin
      cnt_d     = s1_two_q ? 2'd2 : 2'd1;
      o0_pix_d  = first_pix;
      o0_end_d  = s1_end0_q;
      o0_last_d = !s1_two_q;
      o1_pix_d  = yuv1_pix;
      o1_end_d  = s1_end1_q;
    end else if (out_acc) begin
      cnt_d     = cnt_q - 2'd1;
      o0_pix_d  = o1_pix_q;
      o0_end_d  = o1_end_q;
      o0_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o0_pix_q  <= o0_pix_d;
    o0_end_q  <= o0_end_d;
    o0_last_q <= o0_last_d;
    o1_pix_q  <= o1_pix_d;
    o1_end_q  <= o1_end_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign red_o       = o0_pix_q.red;
  assign green_o     = o0_pix_q.green;
  assign blue_o      = o0_pix_q.blue;
  assign alpha_o     = o0_pix_q.alpha;
  assign frame_end_o = o0_end_q;
  assign run_last_o  = o0_last_q;

endmodule

`default_nettype wire
